// ===== rtl/svf_pkg.sv =====
package svf_pkg;

  // Sample and coefficient formats
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 20;
  localparam int TANH_ENTRIES   = 256;

  localparam int SIG_FRAC = SAMPLE_BITS - 1;
  localparam int SIG_W    = 32;
  localparam int DIFF_W   = SIG_W + 2;
  localparam int COEF_W   = 24;
  localparam int MIX_W    = 17;
  localparam int MIX_FRAC = 16;
  localparam int MODE_W   = 3;

  localparam logic [COEF_W-1:0] GAIN_ONE = COEF_W'(1) << COEF_FRAC_BITS;
  localparam logic [MIX_W-1:0]  MIX_ONE  = MIX_W'(1) << MIX_FRAC;
  localparam logic [MIX_W-1:0]  MIX_HALF = MIX_W'(1) << (MIX_FRAC - 1);

  // Shared multiplier and accumulator widths
  localparam int MUL_A_BASE = (COEF_W > MIX_W) ? COEF_W : MIX_W;
  localparam int MUL_A_W    = ((MUL_A_BASE > SIG_FRAC) ? MUL_A_BASE : SIG_FRAC) + 1;
  localparam int MUL_B_W    = DIFF_W;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ACC_W      = PROD_W + 1;

  // tanh table: Q2.30 points over [0, 4]
  localparam int TANH_FRAC = 30;
  localparam int TANH_W    = 32;
  localparam int TY_W      = TANH_W + 1;
  localparam int TIDX_W    = $clog2(TANH_ENTRIES + 1);
  localparam int POS_W     = SIG_W + 1 + TIDX_W;
  localparam logic [TANH_W-1:0] Q30_ONE = TANH_W'(1) << TANH_FRAC;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_MODE     = 3'd0,
    REG_GAIN_NORM       = 3'd1,
    REG_INTEGRATOR_GAIN = 3'd2,
    REG_FEEDBACK_GAIN   = 3'd3,
    REG_MIX_AMOUNT      = 3'd4,
    REG_SATURATE_ENABLE = 3'd5,
    REG_DRIVE_GAIN      = 3'd6
  } cfg_reg_t;

  // Filter modes; any code above the mix passes the sample through
  localparam logic [MODE_W-1:0] MODE_LP  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HP  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BP  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MIX = 3'd3;

  // Microcode fields
  localparam int PC_W = 5;

  typedef enum logic [2:0] {
    MA_FB, MA_NORM, MA_G, MA_DRIVE, MA_FRAC, MA_MIX, MA_MIXC
  } mul_a_t;

  typedef enum logic [2:0] {
    MB_S1, MB_ACC, MB_HP, MB_BP, MB_LP, MB_TDIFF
  } mul_b_t;

  typedef enum logic [3:0] {
    ALU_NOP, ALU_DIFF, ALU_HP, ALU_BP, ALU_TSPLIT, ALU_TLOADA, ALU_TLOADB,
    ALU_TY, ALU_TOUT, ALU_LP, ALU_S2, ALU_MIX1, ALU_MIX2
  } alu_op_t;

  typedef enum logic [1:0] {
    JC_NONE, JC_BYPASS, JC_NOSAT, JC_NOMIX
  } cond_t;

  typedef struct packed {
    mul_a_t            mul_a;
    mul_b_t            mul_b;
    logic              mul_en;
    alu_op_t           alu;
    cond_t             cond;
    logic [PC_W-1:0]   target;
    logic              last;
  } uword_t;

  // Program step addresses
  localparam logic [PC_W-1:0] STEP_MUL_FB  = 5'd0;
  localparam logic [PC_W-1:0] STEP_DIFF    = 5'd1;
  localparam logic [PC_W-1:0] STEP_MUL_N   = 5'd2;
  localparam logic [PC_W-1:0] STEP_HP      = 5'd3;
  localparam logic [PC_W-1:0] STEP_MUL_G1  = 5'd4;
  localparam logic [PC_W-1:0] STEP_BP      = 5'd5;
  localparam logic [PC_W-1:0] STEP_MUL_D   = 5'd6;
  localparam logic [PC_W-1:0] STEP_TSPLIT  = 5'd7;
  localparam logic [PC_W-1:0] STEP_TLOADA  = 5'd8;
  localparam logic [PC_W-1:0] STEP_TLOADB  = 5'd9;
  localparam logic [PC_W-1:0] STEP_MUL_F   = 5'd10;
  localparam logic [PC_W-1:0] STEP_TY      = 5'd11;
  localparam logic [PC_W-1:0] STEP_TOUT    = 5'd12;
  localparam logic [PC_W-1:0] STEP_MUL_G2  = 5'd13;
  localparam logic [PC_W-1:0] STEP_LP      = 5'd14;
  localparam logic [PC_W-1:0] STEP_S2      = 5'd15;
  localparam logic [PC_W-1:0] STEP_MIX1    = 5'd16;
  localparam logic [PC_W-1:0] STEP_MIX2    = 5'd17;
  localparam logic [PC_W-1:0] STEP_OUT     = 5'd18;

  // Control store: one word per step
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w.mul_a  = MA_FB;
    w.mul_b  = MB_S1;
    w.mul_en = 1'b0;
    w.alu    = ALU_NOP;
    w.cond   = JC_NONE;
    w.target = STEP_OUT;
    w.last   = 1'b0;
    case (pc)
      STEP_MUL_FB: begin
        w.mul_a = MA_FB; w.mul_b = MB_S1; w.mul_en = 1'b1;
        w.cond = JC_BYPASS; w.target = STEP_OUT;
      end
      STEP_DIFF:   w.alu = ALU_DIFF;
      STEP_MUL_N: begin
        w.mul_a = MA_NORM; w.mul_b = MB_ACC; w.mul_en = 1'b1;
      end
      STEP_HP:     w.alu = ALU_HP;
      STEP_MUL_G1: begin
        w.mul_a = MA_G; w.mul_b = MB_HP; w.mul_en = 1'b1;
      end
      STEP_BP: begin
        w.alu = ALU_BP; w.cond = JC_NOSAT; w.target = STEP_MUL_G2;
      end
      STEP_MUL_D: begin
        w.mul_a = MA_DRIVE; w.mul_b = MB_BP; w.mul_en = 1'b1;
      end
      STEP_TSPLIT: w.alu = ALU_TSPLIT;
      STEP_TLOADA: w.alu = ALU_TLOADA;
      STEP_TLOADB: w.alu = ALU_TLOADB;
      STEP_MUL_F: begin
        w.mul_a = MA_FRAC; w.mul_b = MB_TDIFF; w.mul_en = 1'b1;
      end
      STEP_TY:     w.alu = ALU_TY;
      STEP_TOUT:   w.alu = ALU_TOUT;
      STEP_MUL_G2: begin
        w.mul_a = MA_G; w.mul_b = MB_BP; w.mul_en = 1'b1;
      end
      STEP_LP:     w.alu = ALU_LP;
      STEP_S2: begin
        w.alu = ALU_S2; w.mul_a = MA_MIX; w.mul_b = MB_HP; w.mul_en = 1'b1;
        w.cond = JC_NOMIX; w.target = STEP_OUT;
      end
      STEP_MIX1: begin
        w.alu = ALU_MIX1; w.mul_a = MA_MIXC; w.mul_b = MB_LP; w.mul_en = 1'b1;
      end
      STEP_MIX2:   w.alu = ALU_MIX2;
      STEP_OUT:    w.last = 1'b1;
      default:     w.last = 1'b1;
    endcase
    return w;
  endfunction

  // Shift-subtract long division, used only while building the constant table
  function automatic longint long_div(input longint num, input longint den);
    longint q;
    longint rem;
    q   = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem << 1) | ((num >> b) & 64'sd1);
      if (rem >= den) begin
        rem = rem - den;
        q   = q | (64'sd1 << b);
      end
    end
    return q;
  endfunction

  typedef logic [TANH_W-1:0] tanh_lut_t [TANH_ENTRIES+1];

  // e^-2x from a 17-term series at x/8, squared four times; tanh = (1-e)/(1+e)
  function automatic tanh_lut_t build_tanh();
    tanh_lut_t lut;
    longint    one;
    longint    z;
    longint    term;
    longint    e;
    one = 64'sd1 << TANH_FRAC;
    for (int i = 0; i <= TANH_ENTRIES; i++) begin
      z    = (longint'(i) << 29) / TANH_ENTRIES;
      term = one;
      e    = one;
      for (int k = 1; k <= 16; k++) begin
        term = long_div((term * z) >>> 30, longint'(k));
        if (k % 2 == 1) e = e - term;
        else            e = e + term;
      end
      for (int k = 0; k < 4; k++) e = (e * e) >>> 30;
      if (e > one) e = one;
      if (e < 0)   e = 0;
      lut[i] = TANH_W'(long_div((one - e) << 30, one + e));
    end
    return lut;
  endfunction

  localparam tanh_lut_t TANH_LUT = build_tanh();

endpackage

// ===== rtl/sem_state_variable_filter.sv =====
// Two-pole state-variable filter, one signed Q1.23 sample per beat. A small
// microprogram steps a single shared multiplier and adder through the highpass,
// bandpass (with optional tanh saturation via a 257-point table and linear
// interpolation) and lowpass, then updates both integrators. Each multiply
// takes one step and its scaled result is used in the next. No new sample is
// taken while a program runs: bypass jumps straight to the emit step, the
// saturator steps run only when enabled and the mix steps only in mix mode;
// the input is taken again in the cycle after the program finishes. Results sit
// in an output register, so a new sample is taken while the last one waits; the
// final step holds only if that register is still full. Configuration writes
// land at once and must be made while no sample is in flight.
module sem_state_variable_filter
  import svf_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam logic signed [ACC_W-1:0] SIG_HI =
    {{(ACC_W-SIG_W+1){1'b0}}, {(SIG_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SIG_LO = ~SIG_HI;
  localparam logic signed [ACC_W-1:0] SMP_HI =
    {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SMP_LO = ~SMP_HI;

  function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [ACC_W-1:0] v);
    if (v > SIG_HI)      return SIG_HI[SIG_W-1:0];
    else if (v < SIG_LO) return SIG_LO[SIG_W-1:0];
    else                 return v[SIG_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(
    input logic signed [ACC_W-1:0] v);
    if (v > SMP_HI)      return SMP_HI[SAMPLE_BITS-1:0];
    else if (v < SMP_LO) return SMP_LO[SAMPLE_BITS-1:0];
    else                 return v[SAMPLE_BITS-1:0];
  endfunction

  // Configuration registers
  logic [MODE_W-1:0] filter_mode_r;
  logic [COEF_W-1:0] gain_norm_r;
  logic [COEF_W-1:0] integrator_gain_r;
  logic [COEF_W-1:0] feedback_gain_r;
  logic [MIX_W-1:0]  mix_amount_r;
  logic              saturate_enable_r;
  logic [COEF_W-1:0] drive_gain_r;

  // Sequencer
  logic              busy_r, busy_nxt;
  logic [PC_W-1:0]   pc_r, pc_nxt;
  uword_t            uw;
  logic              jump;
  logic              out_free;

  // Output register
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_data_r, out_data_nxt;
  logic signed [SAMPLE_BITS-1:0] result_sel;

  // Datapath registers
  logic signed [SAMPLE_BITS-1:0] x_r, x_nxt;
  logic signed [SIG_W-1:0]       s1_r, s1_nxt;
  logic signed [SIG_W-1:0]       s2_r, s2_nxt;
  logic signed [SIG_W-1:0]       hp_r, hp_nxt;
  logic signed [SIG_W-1:0]       bp_r, bp_nxt;
  logic signed [SIG_W-1:0]       lp_r, lp_nxt;
  logic signed [SIG_W-1:0]       t_r, t_nxt;
  logic signed [SIG_W-1:0]       u_r, u_nxt;
  logic signed [PROD_W-1:0]      p_r, p_nxt;
  logic signed [ACC_W-1:0]       acc_r, acc_nxt;
  logic signed [SAMPLE_BITS-1:0] mixo_r, mixo_nxt;
  logic                          neg_r, neg_nxt;
  logic                          big_r, big_nxt;
  logic [TIDX_W-1:0]             tidx_r, tidx_nxt;
  logic [SIG_FRAC-1:0]           frac_r, frac_nxt;
  logic [TANH_W-1:0]             ta_r, ta_nxt;
  logic signed [TY_W-1:0]        tdiff_r, tdiff_nxt;
  logic signed [TY_W-1:0]        ty_r, ty_nxt;

  // Datapath wires
  logic [MIX_W-1:0]               mix_w;
  logic [MIX_W-1:0]               mixc_w;
  logic signed [MUL_A_W-1:0]      mul_a;
  logic signed [MUL_B_W-1:0]      mul_b;
  logic signed [PROD_W-1:0]       p_coef;
  logic signed [PROD_W-1:0]       p_sig;
  logic signed [SIG_W-1:0]        cm;
  logic signed [DIFF_W-1:0]       diff_w;
  logic signed [SIG_W:0]          v_ext;
  logic [SIG_W:0]                 mag_w;
  logic [POS_W-1:0]               pos_w;
  logic [POS_W-1:0]               idx_w;
  logic                           big_w;
  logic [TIDX_W-1:0]              tidx_p1;
  logic [TY_W+SIG_FRAC-1:0]       conv_full;
  logic signed [SIG_W-1:0]        conv_w;
  logic signed [ACC_W-1:0]        mix_sum;
  logic signed [ACC_W-1:0]        mix_shift;

  assign in_ready       = !busy_r;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

  assign uw       = ucode(pc_r);
  assign out_free = !out_valid_r || out_ready;

  // Branch conditions
  always_comb begin
    case (uw.cond)
      JC_BYPASS: jump = filter_mode_r > MODE_MIX;
      JC_NOSAT:  jump = !saturate_enable_r;
      JC_NOMIX:  jump = filter_mode_r != MODE_MIX;
      default:   jump = 1'b0;
    endcase
  end

  // Clamp the mix weight to one
  assign mix_w  = (mix_amount_r > MIX_ONE) ? MIX_ONE : mix_amount_r;
  assign mixc_w = MIX_ONE - mix_w;

  // Multiplier operand selection
  always_comb begin
    case (uw.mul_a)
      MA_FB:    mul_a = MUL_A_W'(feedback_gain_r);
      MA_NORM:  mul_a = MUL_A_W'(gain_norm_r);
      MA_G:     mul_a = MUL_A_W'(integrator_gain_r);
      MA_DRIVE: mul_a = MUL_A_W'(drive_gain_r);
      MA_FRAC:  mul_a = MUL_A_W'(frac_r);
      MA_MIX:   mul_a = MUL_A_W'(mix_w);
      MA_MIXC:  mul_a = MUL_A_W'(mixc_w);
      default:  mul_a = '0;
    endcase
    case (uw.mul_b)
      MB_S1:    mul_b = MUL_B_W'(s1_r);
      MB_ACC:   mul_b = acc_r[MUL_B_W-1:0];
      MB_HP:    mul_b = MUL_B_W'(hp_r);
      MB_BP:    mul_b = MUL_B_W'(bp_r);
      MB_LP:    mul_b = MUL_B_W'(lp_r);
      MB_TDIFF: mul_b = MUL_B_W'(tdiff_r);
      default:  mul_b = '0;
    endcase
  end

  // Scale the registered product back to signal format (floor) and clip
  assign p_coef = p_r >>> COEF_FRAC_BITS;
  assign p_sig  = p_r >>> SIG_FRAC;
  assign cm     = sat_sig(ACC_W'(p_coef));

  assign diff_w = DIFF_W'(x_r) - DIFF_W'(cm) - DIFF_W'(s2_r);

  // tanh table position from the driven bandpass magnitude
  assign v_ext   = (SIG_W+1)'(cm);
  assign mag_w   = v_ext[SIG_W] ? -v_ext : v_ext;
  assign pos_w   = (POS_W'(mag_w) * POS_W'(TANH_ENTRIES)) >> 2;
  assign idx_w   = pos_w >> SIG_FRAC;
  assign big_w   = idx_w >= POS_W'(TANH_ENTRIES);
  assign tidx_p1 = tidx_r + TIDX_W'(1);

  // Q2.30 tanh value to signal format
  assign conv_full = {ty_r, {SIG_FRAC{1'b0}}} >> TANH_FRAC;
  assign conv_w    = conv_full[SIG_W-1:0];

  assign mix_sum   = acc_r + ACC_W'(p_r);
  assign mix_shift = mix_sum >>> MIX_FRAC;

  // Response select for the output register
  always_comb begin
    case (filter_mode_r)
      MODE_LP:  result_sel = sat_smp(ACC_W'(lp_r));
      MODE_HP:  result_sel = sat_smp(ACC_W'(hp_r));
      MODE_BP:  result_sel = sat_smp(ACC_W'(bp_r));
      MODE_MIX: result_sel = mixo_r;
      default:  result_sel = x_r;
    endcase
  end

  // Sequencer: accept a beat, run the program, emit into the output register
  always_comb begin
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    x_nxt         = x_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (in_valid && in_ready) begin
      busy_nxt = 1'b1;
      pc_nxt   = STEP_MUL_FB;
      x_nxt    = in_sample_in;
    end else if (busy_r) begin
      if (uw.last) begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = result_sel;
          busy_nxt      = 1'b0;
        end
      end else if (jump) begin
        pc_nxt = uw.target;
      end else begin
        pc_nxt = pc_r + PC_W'(1);
      end
    end
  end

  // Datapath: execute the current control word
  always_comb begin
    s1_nxt    = s1_r;
    s2_nxt    = s2_r;
    hp_nxt    = hp_r;
    bp_nxt    = bp_r;
    lp_nxt    = lp_r;
    t_nxt     = t_r;
    u_nxt     = u_r;
    p_nxt     = p_r;
    acc_nxt   = acc_r;
    mixo_nxt  = mixo_r;
    neg_nxt   = neg_r;
    big_nxt   = big_r;
    tidx_nxt  = tidx_r;
    frac_nxt  = frac_r;
    ta_nxt    = ta_r;
    tdiff_nxt = tdiff_r;
    ty_nxt    = ty_r;
    if (busy_r) begin
      if (uw.mul_en) p_nxt = mul_a * mul_b;
      case (uw.alu)
        ALU_DIFF: acc_nxt = ACC_W'(diff_w);
        ALU_HP:   hp_nxt  = cm;
        ALU_BP: begin
          t_nxt  = cm;
          bp_nxt = sat_sig(ACC_W'(cm) + ACC_W'(s1_r));
        end
        ALU_TSPLIT: begin
          neg_nxt  = v_ext[SIG_W];
          big_nxt  = big_w;
          tidx_nxt = big_w ? '0 : idx_w[TIDX_W-1:0];
          frac_nxt = pos_w[SIG_FRAC-1:0];
        end
        ALU_TLOADA: ta_nxt = TANH_LUT[tidx_r];
        ALU_TLOADB: tdiff_nxt = TY_W'(TANH_LUT[tidx_p1]) - TY_W'(ta_r);
        ALU_TY:     ty_nxt = big_r ? TY_W'(Q30_ONE) : TY_W'(ta_r) + TY_W'(p_sig);
        ALU_TOUT:   bp_nxt = neg_r ? -conv_w : conv_w;
        ALU_LP: begin
          u_nxt  = cm;
          lp_nxt = sat_sig(ACC_W'(cm) + ACC_W'(s2_r));
          s1_nxt = sat_sig(ACC_W'(t_r) + ACC_W'(bp_r));
        end
        ALU_S2:   s2_nxt   = sat_sig(ACC_W'(u_r) + ACC_W'(lp_r));
        ALU_MIX1: acc_nxt  = ACC_W'(p_r);
        ALU_MIX2: mixo_nxt = sat_smp(mix_shift);
        default:  ;
      endcase
    end
  end

  // Control state, integrators and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r            <= 1'b0;
      pc_r              <= STEP_MUL_FB;
      out_valid_r       <= 1'b0;
      s1_r              <= '0;
      s2_r              <= '0;
      filter_mode_r     <= MODE_LP;
      gain_norm_r       <= GAIN_ONE;
      integrator_gain_r <= GAIN_ONE;
      feedback_gain_r   <= GAIN_ONE;
      mix_amount_r      <= MIX_HALF;
      saturate_enable_r <= 1'b0;
      drive_gain_r      <= GAIN_ONE;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      s1_r        <= s1_nxt;
      s2_r        <= s2_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_FILTER_MODE:     filter_mode_r     <= cfg_data[MODE_W-1:0];
          REG_GAIN_NORM:       gain_norm_r       <= cfg_data[COEF_W-1:0];
          REG_INTEGRATOR_GAIN: integrator_gain_r <= cfg_data[COEF_W-1:0];
          REG_FEEDBACK_GAIN:   feedback_gain_r   <= cfg_data[COEF_W-1:0];
          REG_MIX_AMOUNT:      mix_amount_r      <= cfg_data[MIX_W-1:0];
          REG_SATURATE_ENABLE: saturate_enable_r <= cfg_data[0];
          REG_DRIVE_GAIN:      drive_gain_r      <= cfg_data[COEF_W-1:0];
          default:             ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    x_r        <= x_nxt;
    hp_r       <= hp_nxt;
    bp_r       <= bp_nxt;
    lp_r       <= lp_nxt;
    t_r        <= t_nxt;
    u_r        <= u_nxt;
    p_r        <= p_nxt;
    acc_r      <= acc_nxt;
    mixo_r     <= mixo_nxt;
    neg_r      <= neg_nxt;
    big_r      <= big_nxt;
    tidx_r     <= tidx_nxt;
    frac_r     <= frac_nxt;
    ta_r       <= ta_nxt;
    tdiff_r    <= tdiff_nxt;
    ty_r       <= ty_nxt;
  end

  // The program counter never runs past the emit step
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> pc_r <= STEP_OUT)
    else $error("sequencer ran past the last step");

  // The upper interpolation point stays inside the table
  a_tidx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && uw.alu == ALU_TLOADB |-> tidx_r < TIDX_W'(TANH_ENTRIES))
    else $error("tanh table read beyond its last point");

  // A result beat appears only from the final step of a running program
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(busy_r && uw.last))
    else $error("result beat raised outside the emit step");

endmodule

// ===== tb/svf_checker.sv =====
`timescale 1ns / 1ps
module svf_checker
  import svf_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  output int                            errors,
  output int                            pending
);

  localparam longint T_ONE = longint'(1) << TANH_FRAC;

  // Local copy of the register file
  logic [MODE_W-1:0] mode_r;
  logic [COEF_W-1:0] norm_r;
  logic [COEF_W-1:0] g_r;
  logic [COEF_W-1:0] fb_r;
  logic [MIX_W-1:0]  mix_r;
  logic              sat_r;
  logic [COEF_W-1:0] drive_r;

  // Integrator states, SIG_FRAC fraction bits
  longint band_state;
  longint low_state;

  longint                        tanh_points [TANH_ENTRIES+1];
  logic signed [SAMPLE_BITS-1:0] expected_samples [$];
  logic signed [SAMPLE_BITS-1:0] want;

  function automatic longint clip(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Coefficient times signal, floor back to signal format, clip to 32 bits
  function automatic longint scale(input logic [COEF_W-1:0] c, input longint v);
    return clip((longint'(c) * v) >>> COEF_FRAC_BITS, SIG_W);
  endfunction

  // One Q2.30 point of tanh on [0, 4]: e^-2x by series at x/8, squared four times
  function automatic longint tanh_point(input int i);
    longint z;
    longint term;
    longint e;
    z    = (longint'(i) << 29) / TANH_ENTRIES;
    term = T_ONE;
    e    = T_ONE;
    for (int k = 1; k <= 16; k++) begin
      term = ((term * z) >>> 30) / k;
      e    = (k % 2 == 1) ? e - term : e + term;
    end
    repeat (4) e = (e * e) >>> 30;
    if (e > T_ONE) e = T_ONE;
    if (e < 0) e = 0;
    return ((T_ONE - e) << 30) / (T_ONE + e);
  endfunction

  // Odd-symmetric tanh with linear interpolation, flat at one beyond 4.0
  function automatic longint soft_clip(input longint v);
    longint mag;
    longint pos;
    longint idx;
    longint frac;
    longint y;
    mag  = (v < 0) ? -v : v;
    pos  = (mag * TANH_ENTRIES) >>> 2;
    idx  = pos >>> SIG_FRAC;
    frac = pos & ((longint'(1) << SIG_FRAC) - 1);
    if (idx >= TANH_ENTRIES) begin
      y = T_ONE;
    end else begin
      y = tanh_points[idx] +
          (((tanh_points[idx+1] - tanh_points[idx]) * frac) >>> SIG_FRAC);
    end
    y = (y << SIG_FRAC) >>> TANH_FRAC;
    return (v < 0) ? -y : y;
  endfunction

  // Run one sample through the filter and advance the integrators
  function automatic logic signed [SAMPLE_BITS-1:0] filter_sample(
    input logic signed [SAMPLE_BITS-1:0] x_in
  );
    longint x;
    longint diff;
    longint hp;
    longint bp;
    longint lp;
    longint m;
    longint res;
    x = x_in;
    if (mode_r > MODE_MIX) return x_in;
    diff = x - scale(fb_r, band_state) - low_state;
    hp   = scale(norm_r, diff);
    bp   = clip(scale(g_r, hp) + band_state, SIG_W);
    if (sat_r) bp = soft_clip(scale(drive_r, bp));
    lp   = clip(scale(g_r, bp) + low_state, SIG_W);
    m    = (mix_r > MIX_ONE) ? longint'(MIX_ONE) : longint'(mix_r);
    band_state = clip(scale(g_r, hp) + bp, SIG_W);
    low_state  = clip(scale(g_r, bp) + lp, SIG_W);
    case (mode_r)
      MODE_LP: res = lp;
      MODE_HP: res = hp;
      MODE_BP: res = bp;
      default: res = (m * hp + (longint'(MIX_ONE) - m) * lp) >>> MIX_FRAC;
    endcase
    return SAMPLE_BITS'(clip(res, SAMPLE_BITS));
  endfunction

  initial begin
    for (int i = 0; i <= TANH_ENTRIES; i++) tanh_points[i] = tanh_point(i);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_r     = MODE_LP;
      norm_r     = GAIN_ONE;
      g_r        = GAIN_ONE;
      fb_r       = GAIN_ONE;
      mix_r      = MIX_HALF;
      sat_r      = 1'b0;
      drive_r    = GAIN_ONE;
      band_state = 0;
      low_state  = 0;
      errors     = 0;
      expected_samples.delete();
    end else begin
      // Compare each result beat with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          errors++;
          $display("%0t: unexpected sample_out %0d, expected none", $time, out_sample_out);
        end else begin
          want = expected_samples.pop_front();
          if (out_sample_out !== want) begin
            errors++;
            $display("%0t: sample_out mismatch: expected %0d, got %0d",
                     $time, want, out_sample_out);
          end
        end
      end
      // Predict on each accepted sample beat
      if (in_valid && in_ready) expected_samples.push_back(filter_sample(in_sample_in));
      // Track register writes; unknown indexes are dropped
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_FILTER_MODE:     mode_r  = cfg_data[MODE_W-1:0];
          REG_GAIN_NORM:       norm_r  = cfg_data[COEF_W-1:0];
          REG_INTEGRATOR_GAIN: g_r     = cfg_data[COEF_W-1:0];
          REG_FEEDBACK_GAIN:   fb_r    = cfg_data[COEF_W-1:0];
          REG_MIX_AMOUNT:      mix_r   = cfg_data[MIX_W-1:0];
          REG_SATURATE_ENABLE: sat_r   = cfg_data[0];
          REG_DRIVE_GAIN:      drive_r = cfg_data[COEF_W-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_samples.size();
  end

endmodule

// ===== tb/tb_sem_state_variable_filter.sv =====
`timescale 1ns / 1ps
module tb_sem_state_variable_filter;
  import svf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam logic [MODE_W-1:0] MODE_BYPASS = 3'd4;
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [COEF_W-1:0] COEF_MAX = '1;
  localparam logic [MIX_W-1:0]  MIX_MAX  = '1;
  // Leave a margin after the last result
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 30;
  localparam int PHASE_BEATS  = 55;
  localparam int HOLD_CYCLES  = 300;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [COEF_W-1:0] norm;
    logic [COEF_W-1:0] g;
    logic [COEF_W-1:0] fb;
    logic [MIX_W-1:0]  mix;
    logic              sat;
    logic [COEF_W-1:0] drive;
  } filter_cfg_t;

  logic                          clk          = 1'b0;
  logic                          rst_n        = 1'b0;
  logic                          in_valid     = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] in_sample_in = '0;
  logic                          out_valid;
  logic                          out_ready    = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_sample_out;
  logic                          cfg_wr_en    = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index    = '0;
  logic [CFG_DATA_W-1:0]         cfg_data     = '0;

  int errors;
  int pending;
  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  bit hold_req      = 1'b0;
  bit hold_done     = 1'b0;
  int hold_left     = 0;

  filter_cfg_t cfg;

  always #5 clk = ~clk;

  sem_state_variable_filter i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  svf_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .errors         (errors),
    .pending        (pending)
  );

  // Result side: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Offer one sample beat; entered and left at a falling edge
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
  endtask

  // Drain the block, then load every register; narrow ones get junk above their width
  task automatic apply_cfg(input filter_cfg_t c);
    logic [CFG_DATA_W-1:0] d;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    d = CFG_DATA_W'($urandom);
    d[MODE_W-1:0] = c.mode;
    write_reg(REG_FILTER_MODE, d);
    write_reg(REG_GAIN_NORM, c.norm);
    write_reg(REG_INTEGRATOR_GAIN, c.g);
    write_reg(REG_FEEDBACK_GAIN, c.fb);
    d = CFG_DATA_W'($urandom);
    d[MIX_W-1:0] = c.mix;
    write_reg(REG_MIX_AMOUNT, d);
    d = CFG_DATA_W'($urandom);
    d[0] = c.sat;
    write_reg(REG_SATURATE_ENABLE, d);
    write_reg(REG_DRIVE_GAIN, c.drive);
    write_reg(REG_NONE, CFG_DATA_W'($urandom));
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [COEF_W-1:0] corner_coef();
    case ($urandom_range(3))
      0:       return '0;
      1:       return COEF_MAX;
      2:       return GAIN_ONE;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  // Mostly a stable tuned filter; sometimes coefficients at their corners
  function automatic filter_cfg_t random_cfg();
    filter_cfg_t c;
    longint two_r;
    longint den;
    c.mode = ($urandom_range(9) < 8) ? MODE_W'($urandom_range(3))
                                     : MODE_W'($urandom_range(4, 7));
    c.sat  = 1'($urandom_range(1));
    c.mix  = ($urandom_range(9) == 0) ? MIX_W'($urandom_range(65537, 131071))
                                      : MIX_W'($urandom_range(0, 65536));
    if ($urandom_range(4) == 0) begin
      c.norm  = corner_coef();
      c.g     = corner_coef();
      c.fb    = corner_coef();
      c.drive = corner_coef();
    end else begin
      c.g   = COEF_W'($urandom_range(20000, 900000));
      two_r = longint'($urandom_range(100000, 2100000));
      c.fb  = COEF_W'(two_r + c.g);
      den   = (longint'(1) << COEF_FRAC_BITS) + ((two_r * c.g) >>> COEF_FRAC_BITS) +
              ((longint'(c.g) * c.g) >>> COEF_FRAC_BITS);
      c.norm  = COEF_W'((longint'(1) << (2 * COEF_FRAC_BITS)) / den);
      c.drive = COEF_W'($urandom_range(1 << 18, (1 << 24) - 1));
    end
    return c;
  endfunction

  // A burst of samples: noise, a large square wave, or a quiet passage
  task automatic run_phase(input int beats);
    int style;
    int amp;
    int period;
    int v;
    style  = $urandom_range(2);
    amp    = $urandom_range(1 << 20, 8388607 - 256);
    period = $urandom_range(2, 40);
    for (int k = 0; k < beats; k++) begin
      case (style)
        0: begin
          case ($urandom_range(9))
            0:       v = $urandom_range(1) ? S_MAX : S_MIN;
            1, 2:    v = int'($urandom_range(8192)) - 4096;
            default: v = $urandom;
          endcase
        end
        1: v = (((k / period) % 2) ? amp : -amp) + int'($urandom_range(255)) - 128;
        default: begin
          if ($urandom_range(19) == 0) v = $urandom;
          else v = int'($urandom_range(512)) - 256;
        end
      endcase
      send_sample(SAMPLE_BITS'(v));
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: full-scale steps and the smallest values
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample('0);
    send_sample(1);
    send_sample(-1);
    send_sample(S_MAX);
    send_sample(S_MAX);
    send_sample(S_MIN);

    // Highpass with every coefficient at full scale
    cfg = '{MODE_HP, COEF_MAX, COEF_MAX, COEF_MAX, '0, 1'b0, COEF_MAX};
    apply_cfg(cfg);
    send_sample(S_MAX);
    send_sample(S_MIN);

    // Saturated bandpass with zero coefficients
    cfg = '{MODE_BP, '0, '0, '0, MIX_ONE, 1'b1, COEF_MAX};
    apply_cfg(cfg);
    send_sample(S_MAX);
    send_sample(S_MIN);

    // Saturated bandpass driven hard into the flat part of tanh
    cfg = '{MODE_BP, GAIN_ONE, GAIN_ONE >> 2, GAIN_ONE, MIX_HALF, 1'b1, COEF_MAX};
    apply_cfg(cfg);
    send_sample(S_MAX);
    send_sample(S_MIN);

    // Mix with the weight above one
    cfg = '{MODE_MIX, GAIN_ONE, GAIN_ONE >> 1, GAIN_ONE, MIX_MAX, 1'b0, '0};
    apply_cfg(cfg);
    send_sample(S_MAX);
    send_sample(S_MIN);

    // Bypass, then the undefined mode codes
    cfg.mode = MODE_BYPASS;
    apply_cfg(cfg);
    send_sample(S_MAX);
    send_sample(S_MIN);
    for (int m = 5; m <= 7; m++) begin
      cfg.mode = MODE_W'(m);
      apply_cfg(cfg);
      send_sample(SAMPLE_BITS'($urandom));
    end

    // Random settings, cycling through the idle and stall profiles
    for (int p = 0; p < PHASES; p++) begin
      cfg = random_cfg();
      apply_cfg(cfg);
      case (p % 4)
        0: begin in_idle_pct = 0;  out_stall_pct <= 0;  end
        1: begin in_idle_pct = 65; out_stall_pct <= 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct <= 65; end
        default: begin in_idle_pct = 18; out_stall_pct <= 18; end
      endcase
      // Hold the result side off while samples keep coming, so the input backs up
      if (p == 4) hold_req <= 1'b1;
      run_phase(PHASE_BEATS);
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/svf_pkg.sv
rtl/sem_state_variable_filter.sv
tb/svf_checker.sv
tb/tb_sem_state_variable_filter.sv
